// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL file that checks its own logic.
// Every check samples on the rising edge of clk and is off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define CHECK_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("check failed: condition does not hold");

// Check that a consequence holds in the same cycle as its cause.
`define CHECK_SAME(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
    else $error("check failed: same-cycle implication");

// Check that a consequence holds in the cycle after its cause.
`define CHECK_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("check failed: next-cycle implication");

`endif

// ===== rtl/ouk_pkg.sv =====
// ----------------------------------------------------------------------------
// ouk_pkg
// Shared sizes, codes and cell control type of the ordered unique key list.
// ----------------------------------------------------------------------------
package ouk_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 32;
  localparam int INDEX_BITS = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  // Control broadcast from the sequencer to every cell of the row
  typedef struct packed {
    logic   compare;   // latch this cell's match against key
    logic   write;     // store key in the cell whose index equals count
    logic   shift;     // cells at or above position take the upper neighbor's key
    key_t   key;
    count_t count;
    index_t position;
  } cell_ctrl_t;

endpackage

// ===== rtl/ouk_cell.sv =====
// ----------------------------------------------------------------------------
// ouk_cell
// One slot of the key row: holds a key, matches it against the broadcast
// key and takes its upper neighbor's key when the row compacts.
// ----------------------------------------------------------------------------
module ouk_cell (
  input  logic                clk,
  input  ouk_pkg::index_t     cell_index,
  input  ouk_pkg::cell_ctrl_t ctrl,
  input  ouk_pkg::key_t       upper_key,
  output ouk_pkg::key_t       slot_key,
  output logic                hit
);

  logic occupied;

  // A slot counts only below the fill level
  assign occupied = ouk_pkg::count_t'(cell_index) < ctrl.count;

  // Latch the match result for the sequencer
  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      hit <= occupied && (slot_key == ctrl.key);
    end
  end

  // Append into the first free slot, or compact down from the neighbor
  always_ff @(posedge clk) begin
    if (ctrl.write && (ouk_pkg::count_t'(cell_index) == ctrl.count)) begin
      slot_key <= ctrl.key;
    end else if (ctrl.shift && (cell_index >= ctrl.position)) begin
      slot_key <= upper_key;
    end
  end

endmodule

// ===== rtl/ordered_unique_key_list_top.sv =====
// ----------------------------------------------------------------------------
// ordered_unique_key_list_top
// Insertion-ordered list of distinct keys kept in a row of compare cells.
// ----------------------------------------------------------------------------
// From transfer to result, the key is matched in every cell at once, the
// registered match row is encoded into a position, then the row is updated
// (a push appends into the first free cell, a pull has the removed key's cell
// and every cell above it take the upper neighbor's key, a clear empties the
// count) and the result is registered. The next command is taken in the cycle
// after the result is loaded, so commands never overlap; a stalled result
// holds the sequencer in its update step. No clearing pass follows reset.
module ordered_unique_key_list_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic [1:0]                           cmd,
  input  logic [ouk_pkg::KEY_BITS-1:0]         key,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [1:0]                           status,
  output logic [ouk_pkg::INDEX_BITS-1:0]       position,
  output logic [ouk_pkg::COUNT_BITS-1:0]       entry_count
);

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENCODE,
    S_APPLY
  } state_t;

  state_t                      state;
  ouk_pkg::cmd_t               cmd_hold;
  ouk_pkg::key_t               key_hold;
  ouk_pkg::count_t             count;
  ouk_pkg::count_t             count_next;
  ouk_pkg::index_t             found_pos;
  logic                        found;
  ouk_pkg::index_t             enc_pos;
  logic [ouk_pkg::CAPACITY-1:0] hits;
  ouk_pkg::key_t               slot_keys [ouk_pkg::CAPACITY];
  ouk_pkg::cell_ctrl_t         ctrl;
  logic                        accept;
  logic                        apply_go;
  ouk_pkg::status_t            status_next;
  ouk_pkg::index_t             pos_next;
  logic                        do_write;
  logic                        do_shift;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign apply_go   = (state == S_APPLY) && (!result_valid || result_ready);

  // Encode the match row; keys are distinct, so at most one cell hits
  always_comb begin
    enc_pos = '0;
    for (int i = 0; i < ouk_pkg::CAPACITY; i++) begin
      if (hits[i]) begin
        enc_pos = enc_pos | ouk_pkg::index_t'(i);
      end
    end
  end

  // Decide the outcome of the held command
  always_comb begin
    status_next = ouk_pkg::ST_DONE;
    pos_next    = '0;
    count_next  = count;
    do_write    = 1'b0;
    do_shift    = 1'b0;
    case (cmd_hold)
      ouk_pkg::CMD_PUSH: begin
        if (found) begin
          status_next = ouk_pkg::ST_PRESENT;
          pos_next    = found_pos;
        end else if (count == ouk_pkg::count_t'(ouk_pkg::CAPACITY)) begin
          status_next = ouk_pkg::ST_FULL;
        end else begin
          pos_next   = count[ouk_pkg::INDEX_BITS-1:0];
          count_next = count + ouk_pkg::count_t'(1);
          do_write   = 1'b1;
        end
      end
      ouk_pkg::CMD_PULL: begin
        if (found) begin
          pos_next   = found_pos;
          count_next = count - ouk_pkg::count_t'(1);
          do_shift   = 1'b1;
        end else begin
          status_next = ouk_pkg::ST_ABSENT;
        end
      end
      ouk_pkg::CMD_FIND: begin
        if (found) begin
          pos_next = found_pos;
        end else begin
          status_next = ouk_pkg::ST_ABSENT;
        end
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  // Broadcast control to the cell row
  always_comb begin
    ctrl.compare  = accept;
    ctrl.write    = apply_go && do_write;
    ctrl.shift    = apply_go && do_shift;
    ctrl.key      = (state == S_IDLE) ? key : key_hold;
    ctrl.count    = count;
    ctrl.position = found_pos;
  end

  // Row of cells, each compacting from its upper neighbor
  for (genvar i = 0; i < ouk_pkg::CAPACITY; i++) begin : g_cell
    ouk_pkg::key_t upper;
    if (i == ouk_pkg::CAPACITY - 1) begin : g_top
      assign upper = slot_keys[i];
    end else begin : g_mid
      assign upper = slot_keys[i+1];
    end
    ouk_cell u_cell (
      .clk        (clk),
      .cell_index (ouk_pkg::index_t'(i)),
      .ctrl       (ctrl),
      .upper_key  (upper),
      .slot_key   (slot_keys[i]),
      .hit        (hits[i])
    );
  end

  // Sequence the command and hold the registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_hold <= ouk_pkg::cmd_t'(cmd);
            key_hold <= key;
            state    <= S_ENCODE;
          end
        end
        S_ENCODE: begin
          found     <= |hits;
          found_pos <= enc_pos;
          state     <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_go) begin
            count        <= count_next;
            status       <= status_next;
            position     <= pos_next;
            entry_count  <= count_next;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Self checks
  `CHECK_ALWAYS(a_count_bound, count <= ouk_pkg::count_t'(ouk_pkg::CAPACITY))
  `CHECK_NEXT(a_one_at_a_time, accept, !item_ready)
  `CHECK_SAME(a_full_means_full, result_valid && (status == ouk_pkg::ST_FULL),
              entry_count == ouk_pkg::count_t'(ouk_pkg::CAPACITY))
  `CHECK_SAME(a_absent_pos_zero, result_valid && (status == ouk_pkg::ST_ABSENT), position == '0)

endmodule
